>>> rtl/atsd_pkg.sv
// Shared widths, reset values and register indexes of the spike detector.
`timescale 1ns / 1ps

package atsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 32;
  localparam int CFG_BITS    = 16;
  localparam int GAP_BITS    = 16;
  localparam int WIN_BITS    = 13;
  localparam int POS_BITS    = 12;
  localparam int WEIGHT_BITS = 16;
  localparam int OFS_BITS    = 15;
  localparam int SINCE_BITS  = 17;

  localparam logic [WIN_BITS-1:0] WIN_MIN = WIN_BITS'(2);
  localparam logic [WIN_BITS-1:0] WIN_MAX = WIN_BITS'(4096);

  localparam logic signed [SAMPLE_BITS-1:0] POS_INIT_RST = SAMPLE_BITS'(128);
  localparam logic signed [SAMPLE_BITS-1:0] NEG_INIT_RST = SAMPLE_BITS'(-128);
  localparam logic [GAP_BITS-1:0]           GAP_RST      = GAP_BITS'(10);
  localparam logic [WIN_BITS-1:0]           WIN_RST      = WIN_BITS'(64);
  localparam logic [WEIGHT_BITS-1:0]        WEIGHT_RST   = WEIGHT_BITS'(3277);
  localparam logic [OFS_BITS-1:0]           OFS_RST      = OFS_BITS'(128);

  typedef enum logic [2:0] {
    CFG_POS_INIT   = 3'd0,
    CFG_NEG_INIT   = 3'd1,
    CFG_TIME_GAP   = 3'd2,
    CFG_WINDOW_LEN = 3'd3,
    CFG_EMA_WEIGHT = 3'd4,
    CFG_NEG_OFFSET = 3'd5
  } cfg_reg_t;

endpackage

>>> rtl/atsd_if.sv
// Stream interfaces: sample input channel and spike result channel.
`timescale 1ns / 1ps

interface atsd_sample_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [atsd_pkg::SAMPLE_BITS-1:0]  sample;
  logic                                     start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface atsd_spike_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     polarity;
  logic signed [atsd_pkg::SAMPLE_BITS-1:0]  amplitude;
  logic [atsd_pkg::INDEX_BITS-1:0]          spike_index;

  modport source (output valid, output polarity, output amplitude, output spike_index,
                  input ready);
  modport sink   (input valid, input polarity, input amplitude, input spike_index,
                  output ready);
endinterface

>>> rtl/adaptive_threshold_spike_detector_core.sv
// Top level of the adaptive-threshold spike detector.
`timescale 1ns / 1ps

// Adaptive-threshold spike detector.
// samples: input stream of Q8.8 accelerometer samples; start_req marks the
//   first sample of a record (index 0, thresholds reloaded from pos_init and
//   neg_init, block state cleared). Each sample judges the one before it.
// spikes: one transfer per detected peak or trough, carrying polarity,
//   the candidate value and its index within the record.
// cfg_we/cfg_index/cfg_data: register writes, taken on any cycle with
//   cfg_we high; indexes beyond the register list are ignored.
// Throughput: one sample per cycle unless stalled (see Stall); the other bubble
//   is the cycle right after a register write, while the EMA product register
//   picks up the new weight. A spike is registered and appears on the spikes
//   channel in the cycle after the transfer of the sample that judges it.
// The threshold EMA products are registered from the stored thresholds and
//   block extremes; they settle between a block closing and the update two
//   samples later, so the update adds no stall.
// Stall: a single output register holds a pending spike; while it is full
//   and spikes.ready is low, samples.ready is low.
// Reset: synchronous, active high; registers return to defaults and the
//   stream behaves as a record begun at reset.
module adaptive_threshold_spike_detector_core (
  input  logic                              clk,
  input  logic                              rst,
  atsd_sample_if.sink                       samples,
  atsd_spike_if.source                      spikes,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [atsd_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int SB  = atsd_pkg::SAMPLE_BITS;
  localparam int IB  = atsd_pkg::INDEX_BITS;
  localparam int WNB = atsd_pkg::WIN_BITS;
  localparam int PSB = atsd_pkg::POS_BITS;
  localparam int SSB = atsd_pkg::SINCE_BITS;
  localparam int GB  = atsd_pkg::GAP_BITS;
  localparam int CB  = (IB > WNB + 1) ? IB : WNB + 1;

  // configuration registers
  logic signed [SB-1:0]              pos_init;
  logic signed [SB-1:0]              neg_init;
  logic [GB-1:0]                     time_gap;
  logic [WNB-1:0]                    window_len;
  logic [atsd_pkg::WEIGHT_BITS-1:0]  ema_weight;
  logic [atsd_pkg::OFS_BITS-1:0]     neg_offset;
  logic                              cfg_hold;

  // detector state
  logic [IB-1:0]         sample_count;
  logic signed [SB-1:0]  older_sample;
  logic signed [SB-1:0]  candidate_sample;
  logic signed [SB-1:0]  pos_threshold;
  logic signed [SB-1:0]  neg_threshold;
  logic signed [SB-1:0]  running_max;
  logic signed [SB-1:0]  running_min;
  logic signed [SB-1:0]  block_max;
  logic signed [SB-1:0]  block_min;
  logic [PSB-1:0]        block_position;
  logic [SSB-1:0]        since_spike;

  // result register
  logic                  out_valid;
  logic                  out_polarity;
  logic signed [SB-1:0]  out_amplitude;
  logic [IB-1:0]         out_index;

  // next values
  logic [IB-1:0]         sample_count_next;
  logic signed [SB-1:0]  pos_threshold_next;
  logic signed [SB-1:0]  neg_threshold_next;
  logic signed [SB-1:0]  running_max_next;
  logic signed [SB-1:0]  running_min_next;
  logic signed [SB-1:0]  block_max_next;
  logic signed [SB-1:0]  block_min_next;
  logic [PSB-1:0]        block_position_next;
  logic [SSB-1:0]        since_spike_next;

  logic                  accept;
  logic                  start;
  logic [IB-1:0]         n_eff;
  logic [PSB-1:0]        p_eff;
  logic [SSB-1:0]        since_eff;
  logic [WNB-1:0]        win;
  logic [WNB:0]          win_plus1;
  logic                  judge;
  logic                  update;
  logic                  close;
  logic                  pos_hit;
  logic                  neg_hit;
  logic                  fire;
  logic signed [SB-1:0]  pos_ema;
  logic signed [SB-1:0]  neg_ema;
  logic signed [SB-1:0]  x;

  // EMA toward the last block's extremes; offset only on the negative side
  atsd_ema u_pos_ema (
    .clk    (clk),
    .th     (pos_threshold),
    .ext    (block_max),
    .weight (ema_weight),
    .offset ('0),
    .result (pos_ema)
  );

  atsd_ema u_neg_ema (
    .clk    (clk),
    .th     (neg_threshold),
    .ext    (block_min),
    .weight (ema_weight),
    .offset (neg_offset),
    .result (neg_ema)
  );

  assign accept = samples.valid && samples.ready;
  assign samples.ready = (!out_valid || spikes.ready) && !cfg_hold;
  assign x = samples.sample;
  assign start = samples.start_req;

  // window clamped to its legal range
  always_comb begin
    if (window_len < atsd_pkg::WIN_MIN) begin
      win = atsd_pkg::WIN_MIN;
    end else if (window_len > atsd_pkg::WIN_MAX) begin
      win = atsd_pkg::WIN_MAX;
    end else begin
      win = window_len;
    end
  end
  assign win_plus1 = {1'b0, win} + (WNB+1)'(1);

  always_comb begin
    // record start acts before the sample is processed
    n_eff     = start ? '0 : sample_count;
    p_eff     = start ? '0 : block_position;
    since_eff = start ? '1 : since_spike;

    judge  = (n_eff >= IB'(2));
    // second sample of a new block, from the second boundary on
    update = judge && (p_eff == PSB'(1)) && (CB'(n_eff) > CB'(win_plus1));

    if (update) begin
      pos_threshold_next = pos_ema;
      neg_threshold_next = neg_ema;
    end else if (start) begin
      pos_threshold_next = pos_init;
      neg_threshold_next = neg_init;
    end else begin
      pos_threshold_next = pos_threshold;
      neg_threshold_next = neg_threshold;
    end

    pos_hit = (candidate_sample > pos_threshold_next) && (older_sample < candidate_sample)
              && (x < candidate_sample);
    neg_hit = (candidate_sample < neg_threshold_next) && (older_sample > candidate_sample)
              && (x > candidate_sample);
    fire = judge && (pos_hit || neg_hit) && (since_eff > {1'b0, time_gap});

    if (fire) begin
      since_spike_next = SSB'(1);
    end else if (judge && (since_eff != '1)) begin
      since_spike_next = since_eff + SSB'(1);
    end else begin
      since_spike_next = since_eff;
    end

    if (p_eff == '0) begin
      running_max_next = x;
      running_min_next = x;
    end else begin
      running_max_next = (x > running_max) ? x : running_max;
      running_min_next = (x < running_min) ? x : running_min;
    end

    close = ({1'b0, p_eff} >= (win - WNB'(1)));
    if (close) begin
      block_max_next      = running_max_next;
      block_min_next      = running_min_next;
      block_position_next = '0;
    end else begin
      block_max_next      = start ? '0 : block_max;
      block_min_next      = start ? '0 : block_min;
      block_position_next = p_eff + PSB'(1);
    end

    // index saturates at its maximum
    sample_count_next = (n_eff != '1) ? n_eff + IB'(1) : n_eff;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_init   <= atsd_pkg::POS_INIT_RST;
      neg_init   <= atsd_pkg::NEG_INIT_RST;
      time_gap   <= atsd_pkg::GAP_RST;
      window_len <= atsd_pkg::WIN_RST;
      ema_weight <= atsd_pkg::WEIGHT_RST;
      neg_offset <= atsd_pkg::OFS_RST;
      cfg_hold   <= 1'b0;
    end else begin
      cfg_hold <= cfg_we;
      if (cfg_we) begin
        unique case (atsd_pkg::cfg_reg_t'(cfg_index))
          atsd_pkg::CFG_POS_INIT:   pos_init   <= SB'($signed(cfg_data));
          atsd_pkg::CFG_NEG_INIT:   neg_init   <= SB'($signed(cfg_data));
          atsd_pkg::CFG_TIME_GAP:   time_gap   <= cfg_data[GB-1:0];
          atsd_pkg::CFG_WINDOW_LEN: window_len <= cfg_data[WNB-1:0];
          atsd_pkg::CFG_EMA_WEIGHT: ema_weight <= cfg_data[atsd_pkg::WEIGHT_BITS-1:0];
          atsd_pkg::CFG_NEG_OFFSET: neg_offset <= cfg_data[atsd_pkg::OFS_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // detector state, advanced on each sample transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= '0;
      older_sample     <= '0;
      candidate_sample <= '0;
      pos_threshold    <= atsd_pkg::POS_INIT_RST;
      neg_threshold    <= atsd_pkg::NEG_INIT_RST;
      running_max      <= '0;
      running_min      <= '0;
      block_max        <= '0;
      block_min        <= '0;
      block_position   <= '0;
      since_spike      <= '1;
    end else if (accept) begin
      sample_count     <= sample_count_next;
      older_sample     <= candidate_sample;
      candidate_sample <= x;
      pos_threshold    <= pos_threshold_next;
      neg_threshold    <= neg_threshold_next;
      running_max      <= running_max_next;
      running_min      <= running_min_next;
      block_max        <= block_max_next;
      block_min        <= block_min_next;
      block_position   <= block_position_next;
      since_spike      <= since_spike_next;
    end
  end

  // output register; ready gating guarantees a pending spike is never overwritten
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= fire;
    end else if (spikes.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      out_polarity  <= !pos_hit;
      out_amplitude <= candidate_sample;
      out_index     <= n_eff - IB'(1);
    end
  end

  assign spikes.valid       = out_valid;
  assign spikes.polarity    = out_polarity;
  assign spikes.amplitude   = out_amplitude;
  assign spikes.spike_index = out_index;

endmodule

>>> rtl/atsd_ema.sv
// Threshold EMA unit: registered weight product, rounding, offset and saturation.
`timescale 1ns / 1ps

module atsd_ema (
  input  logic                                    clk,
  input  logic signed [atsd_pkg::SAMPLE_BITS-1:0] th,
  input  logic signed [atsd_pkg::SAMPLE_BITS-1:0] ext,
  input  logic [atsd_pkg::WEIGHT_BITS-1:0]        weight,
  input  logic [atsd_pkg::OFS_BITS-1:0]           offset,
  output logic signed [atsd_pkg::SAMPLE_BITS-1:0] result
);

  localparam int SB = atsd_pkg::SAMPLE_BITS;
  localparam int WB = atsd_pkg::WEIGHT_BITS;
  localparam int PB = SB + WB + 2;
  localparam int AB = PB + 1;
  localparam int RB = AB - WB + 1;
  localparam logic signed [AB-1:0] HALF = AB'(1) <<< (WB - 1);

  logic signed [SB:0]    diff;
  logic signed [WB:0]    wt;
  logic signed [PB-1:0]  prod;
  logic signed [AB-1:0]  acc;
  logic signed [AB-WB-1:0] scaled;
  logic signed [RB-1:0]  shifted;
  logic                  fits;

  // th + (ext - th) * w, i.e. th*(1-w) + ext*w in Q0.16
  assign diff = $signed({ext[SB-1], ext}) - $signed({th[SB-1], th});
  assign wt   = $signed({1'b0, weight});

  always_ff @(posedge clk) begin
    prod <= PB'(diff) * PB'(wt);
  end

  // round half up, floor shift
  assign acc     = (AB'(th) <<< WB) + AB'(prod) + HALF;
  assign scaled  = acc[AB-1:WB];
  assign shifted = RB'(scaled) - RB'($signed({1'b0, offset}));
  assign fits    = (&shifted[RB-1:SB-1]) || ~(|shifted[RB-1:SB-1]);

  always_comb begin
    if (fits) begin
      result = shifted[SB-1:0];
    end else if (shifted[RB-1]) begin
      result = {1'b1, {(SB-1){1'b0}}};
    end else begin
      result = {1'b0, {(SB-1){1'b1}}};
    end
  end

endmodule
